// ===== rtl/ttl_pkg.sv =====
package ttl_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int KEY_BITS_DEF      = 40;

    localparam int OP_W      = 2;
    localparam int TOKEN_W   = 40;
    localparam int TIME_W    = 31;
    localparam int EXP_W     = 32;
    localparam int COUNT_W   = 7;
    localparam int STATUS_W  = 2;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int COUNT_MAX = 127;

    localparam logic [OP_W-1:0] OP_GENERATE = 2'd0;
    localparam logic [OP_W-1:0] OP_RENEW    = 2'd1;
    localparam logic [OP_W-1:0] OP_COUNT    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    localparam logic [PADDR_W-3:0] REG_TTL = 1'b0;

    typedef struct packed {
        logic found;
        logic match_live;
        logic free_found;
    } t_scan_flags;

endpackage

// ===== rtl/ttl_ram.sv =====
module ttl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ttl_eval.sv =====
module ttl_eval #(
    parameter int IDX_W    = 6,
    parameter int CNT_W    = 7,
    parameter int KEY_BITS = 40
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_en,
    input  logic [IDX_W-1:0]          i_idx,
    input  logic                      i_word_valid,
    input  logic [ttl_pkg::EXP_W-1:0] i_word_expiry,
    input  logic [KEY_BITS-1:0]       i_word_key,
    input  logic [KEY_BITS-1:0]       i_key,
    input  logic [ttl_pkg::TIME_W-1:0] i_now,
    output ttl_pkg::t_scan_flags      o_flags,
    output logic [IDX_W-1:0]          o_match_idx,
    output logic [IDX_W-1:0]          o_free_idx,
    output logic [CNT_W-1:0]          o_count
);

    ttl_pkg::t_scan_flags r_flags;
    logic [IDX_W-1:0]     r_match_idx;
    logic [IDX_W-1:0]     r_free_idx;
    logic [CNT_W-1:0]     r_count;
    logic                 live;
    logic                 hit;

    assign live = i_word_valid && (i_word_expiry > {1'b0, i_now});
    assign hit  = i_word_valid && (i_word_key == i_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
            r_count <= '0;
        end else if (i_start) begin
            r_flags <= '0;
            r_count <= '0;
        end else if (i_en) begin
            if (hit && !r_flags.found) begin
                r_flags.found      <= 1'b1;
                r_flags.match_live <= live;
            end
            if (!live && !r_flags.free_found) begin
                r_flags.free_found <= 1'b1;
            end
            if (live) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && hit && !r_flags.found) begin
            r_match_idx <= i_idx;
        end
        if (i_en && !live && !r_flags.free_found) begin
            r_free_idx <= i_idx;
        end
    end

    assign o_flags     = r_flags;
    assign o_match_idx = r_match_idx;
    assign o_free_idx  = r_free_idx;
    assign o_count     = r_count;

endmodule

// ===== rtl/ttl_token_table_core.sv =====
// Token table with per-entry expiry.
// Input channel (i_in_valid / o_in_ready): one request item carrying
// i_operation (generate, renew, count), i_token_key and i_current_time.
// Output channel (o_out_valid / i_out_ready): one result item per request,
// o_unexpired_count and o_status, held in an output register.
// Table entries (valid, expiry, key) live in one synchronous RAM. A request
// walks every entry, one read per cycle, then writes back at most one entry.
// A new item is accepted only after the previous one has been scanned and
// its result loaded; the scan uses the single RAM read port.
// Reset: the time-to-live register returns to 1 and the RAM is swept clear,
// one entry per cycle over every entry; o_in_ready stays low then.
// APB writes are taken at any time.
// Stall: a result waits in the output register; the next item is accepted and
// scanned, and its result waits until the previous one has been taken.
module ttl_token_table_core #(
    parameter int TABLE_ENTRIES = ttl_pkg::TABLE_ENTRIES_DEF,
    parameter int KEY_BITS      = ttl_pkg::KEY_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [ttl_pkg::OP_W-1:0]       i_operation,
    input  logic [ttl_pkg::TOKEN_W-1:0]    i_token_key,
    input  logic [ttl_pkg::TIME_W-1:0]     i_current_time,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [ttl_pkg::COUNT_W-1:0]    o_unexpired_count,
    output logic [ttl_pkg::STATUS_W-1:0]   o_status,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ttl_pkg::PADDR_W-1:0]    paddr,
    input  logic [ttl_pkg::PDATA_W-1:0]    pwdata,
    output logic [ttl_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int WORD_W = 1 + ttl_pkg::EXP_W + KEY_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [ttl_pkg::TIME_W-1:0]   r_ttl;
    logic [ttl_pkg::OP_W-1:0]     r_op;
    logic [KEY_BITS-1:0]          r_key;
    logic [ttl_pkg::TIME_W-1:0]   r_now;
    logic [IDX_W-1:0]             r_addr;
    logic                         r_issue_done;
    logic                         r_pend;
    logic                         r_plast;
    logic [IDX_W-1:0]             r_pidx;
    logic                         r_out_valid;
    logic [ttl_pkg::COUNT_W-1:0]  r_out_count;
    logic [ttl_pkg::STATUS_W-1:0] r_out_status;

    logic [KEY_BITS-1:0]          key_in;
    logic                         in_accept;
    logic                         out_free;
    logic                         done_go;
    logic                         slot_we;
    logic [IDX_W-1:0]             slot_idx;
    logic [ttl_pkg::STATUS_W-1:0] n_status;
    logic [ttl_pkg::COUNT_W-1:0]  n_count;
    logic [ttl_pkg::EXP_W-1:0]    exp_new;

    logic                         ram_we;
    logic [IDX_W-1:0]             ram_waddr;
    logic [WORD_W-1:0]            ram_wdata;
    logic                         ram_re;
    logic [WORD_W-1:0]            ram_rdata;

    ttl_pkg::t_scan_flags         flags;
    logic [IDX_W-1:0]             match_idx;
    logic [IDX_W-1:0]             free_idx;
    logic [CNT_W-1:0]             live_count;

    generate
        if (KEY_BITS > ttl_pkg::TOKEN_W) begin : g_key_wide
            assign key_in = {{(KEY_BITS - ttl_pkg::TOKEN_W){1'b0}}, i_token_key};
        end else if (KEY_BITS == ttl_pkg::TOKEN_W) begin : g_key_same
            assign key_in = i_token_key;
        end else begin : g_key_narrow
            assign key_in = i_token_key[KEY_BITS-1:0];
        end
    endgenerate

    // config port
    assign pready = 1'b1;

    always_comb begin
        prdata = '0;
        if (paddr[ttl_pkg::PADDR_W-1:2] == ttl_pkg::REG_TTL) begin
            prdata = {1'b0, r_ttl};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl <= ttl_pkg::TIME_W'(1);
        end else if (psel && penable && pwrite && pready &&
                     paddr[ttl_pkg::PADDR_W-1:2] == ttl_pkg::REG_TTL) begin
            r_ttl <= pwdata[ttl_pkg::TIME_W-1:0];
        end
    end

    assign in_accept  = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign out_free   = !r_out_valid || i_out_ready;
    assign done_go    = (r_state == S_DONE) && out_free;
    assign exp_new    = {1'b0, r_now} + {1'b0, r_ttl};

    always_comb begin
        slot_we  = 1'b0;
        slot_idx = match_idx;
        n_status = ttl_pkg::ST_DONE;
        n_count  = '0;
        case (r_op)
            ttl_pkg::OP_GENERATE: begin
                if (flags.found) begin
                    slot_we = 1'b1;
                end else if (flags.free_found) begin
                    slot_we  = 1'b1;
                    slot_idx = free_idx;
                end else begin
                    n_status = ttl_pkg::ST_FULL;
                end
            end
            ttl_pkg::OP_RENEW: begin
                if (flags.found && flags.match_live) begin
                    slot_we = 1'b1;
                end else begin
                    n_status = ttl_pkg::ST_IGNORED;
                end
            end
            ttl_pkg::OP_COUNT: begin
                if (32'(live_count) > 32'(ttl_pkg::COUNT_MAX)) begin
                    n_count = ttl_pkg::COUNT_W'(ttl_pkg::COUNT_MAX);
                end else begin
                    n_count = ttl_pkg::COUNT_W'(live_count);
                end
            end
            default: begin
                slot_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = '0;
        if (r_state == S_CLEAR) begin
            ram_we = 1'b1;
        end else if (done_go && slot_we) begin
            ram_we    = 1'b1;
            ram_waddr = slot_idx;
            ram_wdata = {1'b1, exp_new, r_key};
        end
    end

    assign ram_re = (r_state == S_SCAN) && !r_issue_done;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_addr == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_pend && r_plast) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_addr       <= '0;
            r_issue_done <= 1'b0;
            r_pend       <= 1'b0;
            r_plast      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= ram_re;
            r_plast <= ram_re && (r_addr == LAST_IDX);
            if (r_state == S_CLEAR) begin
                r_addr <= (r_addr == LAST_IDX) ? '0 : r_addr + 1'b1;
            end else if (in_accept) begin
                r_addr       <= '0;
                r_issue_done <= 1'b0;
            end else if (ram_re) begin
                r_addr <= r_addr + 1'b1;
                if (r_addr == LAST_IDX) begin
                    r_issue_done <= 1'b1;
                end
            end
            if (done_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op  <= i_operation;
            r_key <= key_in;
            r_now <= i_current_time;
        end
        r_pidx <= r_addr;
        if (done_go) begin
            r_out_count  <= n_count;
            r_out_status <= n_status;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_unexpired_count = r_out_count;
    assign o_status          = r_out_status;

    ttl_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    ttl_eval #(
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W),
        .KEY_BITS (KEY_BITS)
    ) u_eval (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (in_accept),
        .i_en          (r_pend),
        .i_idx         (r_pidx),
        .i_word_valid  (ram_rdata[WORD_W-1]),
        .i_word_expiry (ram_rdata[WORD_W-2:KEY_BITS]),
        .i_word_key    (ram_rdata[KEY_BITS-1:0]),
        .i_key         (r_key),
        .i_now         (r_now),
        .o_flags       (flags),
        .o_match_idx   (match_idx),
        .o_free_idx    (free_idx),
        .o_count       (live_count)
    );

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !ram_we)
        else $error("table written during scan");

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_SCAN) && !r_pend)
        else $error("accepted item did not start a scan");

    a_full_only_generate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done_go && n_status == ttl_pkg::ST_FULL) |-> (r_op == ttl_pkg::OP_GENERATE))
        else $error("table full reported for non-generate item");

    a_count_only_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done_go && n_count != '0) |-> (r_op == ttl_pkg::OP_COUNT))
        else $error("nonzero count for non-count item");

endmodule

// ===== verif/ttl_token_table_core_tb.sv =====
`timescale 1ns / 100ps

module ttl_token_table_core_tb;

    localparam int TABLE_ENTRIES = ttl_pkg::TABLE_ENTRIES_DEF;
    localparam int CLK_PERIOD    = 20;
    localparam int POOL_SIZE     = 96;
    localparam logic [ttl_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    class token_table_tracker;
        typedef struct packed {
            logic [ttl_pkg::COUNT_W-1:0]  count;
            logic [ttl_pkg::STATUS_W-1:0] status;
        } t_outcome;

        logic [ttl_pkg::TOKEN_W-1:0] key_of    [TABLE_ENTRIES];
        logic [ttl_pkg::EXP_W-1:0]   expiry_of [TABLE_ENTRIES];
        bit                          used      [TABLE_ENTRIES];
        logic [ttl_pkg::TIME_W-1:0]  lifetime;
        t_outcome                    awaited_results [$];
        int                          mismatches;
        int                          results_checked;

        function new();
            lifetime        = 1;
            mismatches      = 0;
            results_checked = 0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                used[i]      = 1'b0;
                key_of[i]    = '0;
                expiry_of[i] = '0;
            end
        endfunction

        function void set_lifetime(logic [ttl_pkg::TIME_W-1:0] value);
            lifetime = value;
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        function bit is_live(int i, logic [ttl_pkg::TIME_W-1:0] now);
            return used[i] && (expiry_of[i] > {1'b0, now});
        endfunction

        function int lookup(logic [ttl_pkg::TOKEN_W-1:0] key);
            int slot;
            slot = -1;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (slot < 0 && used[i] && key_of[i] == key) begin
                    slot = i;
                end
            end
            return slot;
        endfunction

        function void note_request(logic [ttl_pkg::OP_W-1:0] op,
                                   logic [ttl_pkg::TOKEN_W-1:0] key,
                                   logic [ttl_pkg::TIME_W-1:0] now);
            t_outcome                  res;
            logic [ttl_pkg::EXP_W-1:0] expiry;
            int                        slot;
            int                        live;
            res    = '0;
            expiry = {1'b0, now} + {1'b0, lifetime};
            slot   = lookup(key);
            live   = 0;
            case (op)
                ttl_pkg::OP_GENERATE: begin
                    for (int i = 0; i < TABLE_ENTRIES; i++) begin
                        if (slot < 0 && !is_live(i, now)) begin
                            slot = i;
                        end
                    end
                    if (slot < 0) begin
                        res.status = ttl_pkg::ST_FULL;
                    end else begin
                        key_of[slot]    = key;
                        expiry_of[slot] = expiry;
                        used[slot]      = 1'b1;
                    end
                end
                ttl_pkg::OP_RENEW: begin
                    if (slot >= 0 && is_live(slot, now)) begin
                        expiry_of[slot] = expiry;
                    end else begin
                        res.status = ttl_pkg::ST_IGNORED;
                    end
                end
                ttl_pkg::OP_COUNT: begin
                    for (int i = 0; i < TABLE_ENTRIES; i++) begin
                        if (is_live(i, now)) begin
                            live++;
                        end
                    end
                    if (live > ttl_pkg::COUNT_MAX) begin
                        live = ttl_pkg::COUNT_MAX;
                    end
                    res.count = live[ttl_pkg::COUNT_W-1:0];
                end
                default: begin
                end
            endcase
            awaited_results.push_back(res);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH result %0d: %s", $time, results_checked, msg);
            mismatches++;
        endtask

        task check_result(logic [ttl_pkg::COUNT_W-1:0] count,
                          logic [ttl_pkg::STATUS_W-1:0] status);
            t_outcome want;
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result count=%0d status=%0d",
                                          count, status));
            end else begin
                want = awaited_results.pop_front();
                if (count !== want.count) begin
                    report_mismatch($sformatf("unexpired_count %0d, want %0d",
                                              count, want.count));
                end
                if (status !== want.status) begin
                    report_mismatch($sformatf("status %0d, want %0d", status, want.status));
                end
            end
            results_checked++;
        endtask
    endclass

    logic                           i_clk             = 1'b0;
    logic                           i_rst_n           = 1'b0;
    logic                           i_in_valid        = 1'b0;
    logic                           o_in_ready;
    logic [ttl_pkg::OP_W-1:0]       i_operation       = '0;
    logic [ttl_pkg::TOKEN_W-1:0]    i_token_key       = '0;
    logic [ttl_pkg::TIME_W-1:0]     i_current_time    = '0;
    logic                           o_out_valid;
    logic                           i_out_ready       = 1'b0;
    logic [ttl_pkg::COUNT_W-1:0]    o_unexpired_count;
    logic [ttl_pkg::STATUS_W-1:0]   o_status;
    logic                           psel              = 1'b0;
    logic                           penable           = 1'b0;
    logic                           pwrite            = 1'b0;
    logic [ttl_pkg::PADDR_W-1:0]    paddr             = '0;
    logic [ttl_pkg::PDATA_W-1:0]    pwdata            = '0;
    logic [ttl_pkg::PDATA_W-1:0]    prdata;
    logic                           pready;

    token_table_tracker tracker = new();

    logic [ttl_pkg::TOKEN_W-1:0] key_pool [POOL_SIZE];
    logic [ttl_pkg::TIME_W-1:0]  clock_now;
    bit                          steady       = 1'b0;
    int                          results_seen = 0;
    int                          hold_left    = 0;
    bit                          hold_done    = 1'b0;

    ttl_token_table_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_operation       (i_operation),
        .i_token_key       (i_token_key),
        .i_current_time    (i_current_time),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_unexpired_count (o_unexpired_count),
        .o_status          (o_status),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // receiver: random back-pressure plus one long hold to fill the block
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (!hold_done && results_seen >= 60) begin
            hold_done = 1'b1;
            hold_left = 500;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= steady || ($urandom_range(99) >= 31);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            tracker.check_result(o_unexpired_count, o_status);
        end
    end

    task automatic send_request(input logic [ttl_pkg::OP_W-1:0] op,
                                input logic [ttl_pkg::TOKEN_W-1:0] key,
                                input logic [ttl_pkg::TIME_W-1:0] now);
        while (!steady && $urandom_range(99) < 31) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_operation    <= op;
        i_token_key    <= key;
        i_current_time <= now;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_request(op, key, now);
        @(negedge i_clk);
    endtask

    // lifetime changes only with the block drained
    task automatic set_lifetime(input logic [ttl_pkg::TIME_W-1:0] value);
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {ttl_pkg::REG_TTL, 2'b00};
        pwdata  <= {1'b0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.set_lifetime(value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_phase(input int n_items, input int gen_pct, input int max_step,
                             input int key_span);
        logic [ttl_pkg::OP_W-1:0]    op;
        logic [ttl_pkg::TOKEN_W-1:0] key;
        int                          pick;
        for (int k = 0; k < n_items; k++) begin
            pick = $urandom_range(99);
            if (pick < gen_pct) begin
                op = ttl_pkg::OP_GENERATE;
            end else if (pick < gen_pct + (95 - gen_pct) / 2) begin
                op = ttl_pkg::OP_RENEW;
            end else if (pick < 95) begin
                op = ttl_pkg::OP_COUNT;
            end else begin
                op = OP_UNUSED;
            end
            if ($urandom_range(99) < 8) begin
                key = {8'($urandom()), $urandom()};
            end else begin
                key = key_pool[$urandom_range(key_span - 1)];
            end
            if (max_step < 0 || $urandom_range(99) < 4) begin
                clock_now = 31'($urandom());
            end else begin
                clock_now = clock_now + 31'($urandom_range(max_step));
            end
            send_request(op, key, clock_now);
        end
    endtask

    initial begin
        for (int k = 0; k < POOL_SIZE; k++) begin
            key_pool[k] = {8'($urandom()), $urandom()};
        end
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset lifetime of 1
        send_request(ttl_pkg::OP_COUNT,    '0, 31'd0);
        send_request(ttl_pkg::OP_GENERATE, '0, 31'd0);
        send_request(ttl_pkg::OP_COUNT,    '0, 31'd0);
        send_request(ttl_pkg::OP_RENEW,    '0, 31'd0);
        send_request(ttl_pkg::OP_COUNT,    '0, 31'd1);
        send_request(ttl_pkg::OP_RENEW,    '0, 31'd1);
        send_request(ttl_pkg::OP_GENERATE, '0, 31'd5);
        send_request(ttl_pkg::OP_RENEW,    '1, 31'd5);
        send_request(OP_UNUSED,            key_pool[0], 31'd5);

        set_lifetime(31'h7FFF_FFFF);
        send_request(ttl_pkg::OP_GENERATE, '1, 31'h7FFF_FFFF);
        send_request(ttl_pkg::OP_RENEW,    '1, 31'h7FFF_FFFE);
        send_request(ttl_pkg::OP_COUNT,    '1, 31'h7FFF_FFFF);
        send_request(OP_UNUSED,            '1, 31'h7FFF_FFFF);

        // zero lifetime: entries are born expired
        set_lifetime(31'd0);
        send_request(ttl_pkg::OP_GENERATE, 40'hA5A5A5A5A5, 31'd100);
        send_request(ttl_pkg::OP_COUNT,    40'hA5A5A5A5A5, 31'd100);
        send_request(ttl_pkg::OP_RENEW,    40'hA5A5A5A5A5, 31'd99);
        send_request(ttl_pkg::OP_RENEW,    40'hA5A5A5A5A5, 31'd100);

        // fill the table with live entries, then overflow it
        set_lifetime(31'h4000_0000);
        clock_now = 31'h100;
        for (int k = 0; k < 70; k++) begin
            send_request(ttl_pkg::OP_GENERATE, key_pool[k], clock_now);
        end
        run_phase(60, 50, 0, POOL_SIZE);

        set_lifetime(31'($urandom_range(40, 2)));
        steady    = 1'b1;
        clock_now = 31'h5000_0000;
        run_phase(130, 45, 12, 24);
        steady    = 1'b0;

        set_lifetime(31'd1);
        run_phase(80, 45, 2, 16);

        set_lifetime(31'd1000);
        run_phase(100, 45, 150, 64);

        set_lifetime(31'($urandom_range(32'h7FFF_FFFF, 1)));
        run_phase(100, 45, -1, POOL_SIZE);

        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
        repeat (TABLE_ENTRIES + 16) @(negedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #(400_000 * CLK_PERIOD);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ttl_pkg.sv
rtl/ttl_ram.sv
rtl/ttl_eval.sv
rtl/ttl_token_table_core.sv
verif/ttl_token_table_core_tb.sv
